>>> src/crsr_pkg.sv
`default_nettype none

package crsr_pkg;

  // Default widths of the samples and of the phase fraction.
  localparam int SAMPLE_BITS_DEF     = 24;
  localparam int PHASE_FRAC_BITS_DEF = 16;

  // Width of the register index on the configuration port.
  localparam int CFG_INDEX_BITS = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_MONO_SOURCE = 2'd1,
    CFG_MONO_OUTPUT = 2'd2
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } crsr_state_t;

  // Horner coefficient used in the current accumulate step.
  typedef enum logic [1:0] {
    SEL_C1,
    SEL_C2,
    SEL_D1
  } coef_sel_t;

  // Controls shared by both channel lanes.
  typedef struct packed {
    logic      shift;
    logic      load;
    logic      mul;
    logic      add;
    coef_sel_t sel;
  } lane_ctrl_t;

endpackage

`default_nettype wire

>>> src/crsr_in_if.sv
`default_nettype none

interface crsr_in_if #(
  parameter int SAMPLE_BITS = crsr_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source(output valid, left_sample, right_sample, input ready);
  modport sink(input valid, left_sample, right_sample, output ready);
endinterface

`default_nettype wire

>>> src/crsr_out_if.sv
`default_nettype none

interface crsr_out_if #(
  parameter int SAMPLE_BITS = crsr_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          last_of_run;

  modport source(output valid, left_out, right_out, last_of_run, input ready);
  modport sink(input valid, left_out, right_out, last_of_run, output ready);
endinterface

`default_nettype wire

>>> src/crsr_lane.sv
`default_nettype none

// One channel: four-sample history and a Horner evaluator that uses one
// multiplier over three multiply and accumulate steps.
module crsr_lane #(
  parameter int SAMPLE_BITS     = crsr_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_FRAC_BITS = crsr_pkg::PHASE_FRAC_BITS_DEF,
  parameter int ACC_BITS        = SAMPLE_BITS + 6
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire crsr_pkg::lane_ctrl_t    ctrl,
  input  wire signed [SAMPLE_BITS-1:0] sample,
  input  wire [PHASE_FRAC_BITS-1:0]    frac,
  output logic signed [ACC_BITS-1:0]   y
);

  localparam int PROD_BITS = ACC_BITS + PHASE_FRAC_BITS + 1;
  localparam logic [PROD_BITS-1:0] HALF =
    {{(ACC_BITS + 1){1'b0}}, 1'b1, {(PHASE_FRAC_BITS - 1){1'b0}}};
  localparam logic [ACC_BITS-1:0] ONE_LSB = {{(ACC_BITS - 1){1'b0}}, 1'b1};

  logic signed [SAMPLE_BITS-1:0]   hist [4];
  logic signed [ACC_BITS-1:0]      e0, e1, e2, e3, t12;
  logic signed [ACC_BITS-1:0]      c0, c1, c2, twice_d1, coef;
  logic signed [ACC_BITS-1:0]      h;
  logic signed [ACC_BITS-1:0]      h_inc;
  logic signed [ACC_BITS-1:0]      rnd;
  logic signed [PHASE_FRAC_BITS:0] frac_s;
  logic signed [PROD_BITS-1:0]     prod;
  logic signed [PROD_BITS-1:0]     prod_rnd;

  // History shifts in the newest sample on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        hist[k] <= '0;
      end
    end else if (ctrl.shift) begin
      hist[0] <= hist[1];
      hist[1] <= hist[2];
      hist[2] <= hist[3];
      hist[3] <= sample;
    end
  end

  // Twice the Catmull-Rom coefficients, all integer.
  always_comb begin
    e0       = ACC_BITS'(hist[0]);
    e1       = ACC_BITS'(hist[1]);
    e2       = ACC_BITS'(hist[2]);
    e3       = ACC_BITS'(hist[3]);
    t12      = e1 - e2;
    c0       = e3 - e0 + (t12 <<< 1) + t12;
    c1       = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
    c2       = e2 - e0;
    twice_d1 = e1 <<< 1;
  end

  // Coefficient for the current accumulate step.
  always_comb begin
    unique case (ctrl.sel)
      crsr_pkg::SEL_C1: coef = c1;
      crsr_pkg::SEL_C2: coef = c2;
      crsr_pkg::SEL_D1: coef = twice_d1;
      default:          coef = twice_d1;
    endcase
  end

  // Product rounded to nearest, ties upwards, then scaled back.
  always_comb begin
    frac_s   = $signed({1'b0, frac});
    prod_rnd = prod + $signed(HALF);
    rnd      = $signed(prod_rnd[ACC_BITS+PHASE_FRAC_BITS-1:PHASE_FRAC_BITS]);
  end

  // Multiply and accumulate registers.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      h <= c0;
    end else if (ctrl.add) begin
      h <= coef + rnd;
    end
    if (ctrl.mul) begin
      prod <= h * frac_s;
    end
  end

  // Final halving with rounding.
  always_comb begin
    h_inc = h + $signed(ONE_LSB);
    y     = {h_inc[ACC_BITS-1], h_inc[ACC_BITS-1:1]};
  end

endmodule

`default_nettype wire

>>> src/crsr_merge.sv
`default_nettype none

// Combines the two lanes: optional mono mix, saturation and the output register.
module crsr_merge #(
  parameter int SAMPLE_BITS = crsr_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = SAMPLE_BITS + 6
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire signed [ACC_BITS-1:0] left_y,
  input  wire signed [ACC_BITS-1:0] right_y,
  input  wire                       mono_output,
  input  wire                       load,
  input  wire                       last,
  output logic                      free,
  crsr_out_if.source                out_ch
);

  localparam logic signed [ACC_BITS-1:0] MAX_V =
    {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] MIN_V = ~MAX_V;
  localparam logic [ACC_BITS:0] ONE_LSB = {{ACC_BITS{1'b0}}, 1'b1};

  logic signed [ACC_BITS:0]      mix_sum;
  logic signed [ACC_BITS-1:0]    mix, left_v, right_v;
  logic signed [SAMPLE_BITS-1:0] left_sat, right_sat;
  logic                          valid;

  // Mono mix rounds half the sum upwards.
  always_comb begin
    mix_sum = (ACC_BITS + 1)'(left_y) + (ACC_BITS + 1)'(right_y) + $signed(ONE_LSB);
    mix     = mix_sum[ACC_BITS:1];
    left_v  = mono_output ? mix : left_y;
    right_v = mono_output ? mix : right_y;
  end

  // Saturation to the sample width.
  always_comb begin
    priority if (left_v > MAX_V) begin
      left_sat = MAX_V[SAMPLE_BITS-1:0];
    end else if (left_v < MIN_V) begin
      left_sat = MIN_V[SAMPLE_BITS-1:0];
    end else begin
      left_sat = left_v[SAMPLE_BITS-1:0];
    end
    priority if (right_v > MAX_V) begin
      right_sat = MAX_V[SAMPLE_BITS-1:0];
    end else if (right_v < MIN_V) begin
      right_sat = MIN_V[SAMPLE_BITS-1:0];
    end else begin
      right_sat = right_v[SAMPLE_BITS-1:0];
    end
  end

  // The output register is free when empty or when its transfer completes.
  assign free = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.left_out    <= left_sat;
      out_ch.right_out   <= right_sat;
      out_ch.last_of_run <= last;
    end
  end

  assign out_ch.valid = valid;

endmodule

`default_nettype wire

>>> src/catmull_rom_stereo_resampler.sv
`default_nettype none

// Channel   Direction  Contents
// in_ch     sink       left_sample, right_sample: one stereo source frame
// out_ch    source     left_out, right_out, last_of_run: one output frame
// cfg       write      cfg_we, cfg_index, cfg_data: phase_step, mono_source, mono_output
//
// A frame produces at most eight outputs before the sequencer is ready again.
// For each output the sequencer checks the phase, then each lane loads and runs
// three multiply and accumulate steps on its one shared multiplier, and the
// result moves to the output register.
// Reset is synchronous and clears the history, the sequencer, the configuration and the output valid flag.
// A stalled output holds the sequencer in its emit state; input is taken in idle.
module catmull_rom_stereo_resampler #(
  parameter int SAMPLE_BITS     = crsr_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_FRAC_BITS = crsr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  crsr_in_if.sink                               in_ch,
  crsr_out_if.source                            out_ch,
  input  wire                                   cfg_we,
  input  wire [crsr_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire [PHASE_FRAC_BITS+2:0]             cfg_data
);

  localparam int PW       = PHASE_FRAC_BITS + 3;
  localparam int ACC_BITS = SAMPLE_BITS + 6;
  localparam logic [PW-1:0] ONE_PHASE = {2'b00, 1'b1, {PHASE_FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] STEP_MIN  = {5'b00000, 1'b1, {(PHASE_FRAC_BITS - 3){1'b0}}};
  localparam logic [PW-1:0] STEP_MAX  = {1'b1, {(PHASE_FRAC_BITS + 2){1'b0}}};
  localparam logic [3:0]    MAX_OUT   = 4'd8;
  localparam logic [3:0]    LAST_OUT  = 4'd7;

  crsr_pkg::crsr_state_t state, state_next;
  crsr_pkg::coef_sel_t   iter, iter_next;
  crsr_pkg::lane_ctrl_t  lane_ctrl;
  logic [PW-1:0]         phase, phase_next;
  logic [3:0]            count, count_next;
  logic [PW-1:0]         phase_step;
  logic                  mono_source;
  logic                  mono_output;
  logic [PW-1:0]         step;
  logic [PW-1:0]         phase_sum;
  logic                  merge_load;
  logic                  merge_last;
  logic                  merge_free;
  logic signed [SAMPLE_BITS-1:0] right_in;
  logic signed [ACC_BITS-1:0]    left_y, right_y;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= ONE_PHASE;
      mono_source <= 1'b0;
      mono_output <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crsr_pkg::CFG_PHASE_STEP:  phase_step  <= cfg_data;
        crsr_pkg::CFG_MONO_SOURCE: mono_source <= cfg_data[0];
        crsr_pkg::CFG_MONO_OUTPUT: mono_output <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Step clamped to the range one eighth to four.
  always_comb begin
    priority if (phase_step < STEP_MIN) begin
      step = STEP_MIN;
    end else if (phase_step > STEP_MAX) begin
      step = STEP_MAX;
    end else begin
      step = phase_step;
    end
    phase_sum = phase + step;
  end

  assign right_in = mono_source ? in_ch.left_sample : in_ch.right_sample;

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crsr_pkg::ST_IDLE;
      phase <= '0;
      count <= '0;
      iter  <= crsr_pkg::SEL_C1;
    end else begin
      state <= state_next;
      phase <= phase_next;
      count <= count_next;
      iter  <= iter_next;
    end
  end

  // Next state and controls of the lanes and the merging stage.
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    count_next      = count;
    iter_next       = iter;
    lane_ctrl.shift = 1'b0;
    lane_ctrl.load  = 1'b0;
    lane_ctrl.mul   = 1'b0;
    lane_ctrl.add   = 1'b0;
    lane_ctrl.sel   = iter;
    merge_load      = 1'b0;
    merge_last      = (phase_sum >= ONE_PHASE) || (count == LAST_OUT);
    in_ch.ready     = 1'b0;
    unique case (state)
      crsr_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          lane_ctrl.shift = 1'b1;
          count_next      = '0;
          state_next      = crsr_pkg::ST_CHECK;
        end
      end
      crsr_pkg::ST_CHECK: begin
        if (phase < ONE_PHASE && count != MAX_OUT) begin
          state_next = crsr_pkg::ST_LOAD;
        end else begin
          phase_next = (phase >= ONE_PHASE) ? phase - ONE_PHASE : '0;
          state_next = crsr_pkg::ST_IDLE;
        end
      end
      crsr_pkg::ST_LOAD: begin
        lane_ctrl.load = 1'b1;
        iter_next      = crsr_pkg::SEL_C1;
        state_next     = crsr_pkg::ST_MUL;
      end
      crsr_pkg::ST_MUL: begin
        lane_ctrl.mul = 1'b1;
        state_next    = crsr_pkg::ST_ADD;
      end
      crsr_pkg::ST_ADD: begin
        lane_ctrl.add = 1'b1;
        unique case (iter)
          crsr_pkg::SEL_C1: begin
            iter_next  = crsr_pkg::SEL_C2;
            state_next = crsr_pkg::ST_MUL;
          end
          crsr_pkg::SEL_C2: begin
            iter_next  = crsr_pkg::SEL_D1;
            state_next = crsr_pkg::ST_MUL;
          end
          default: begin
            state_next = crsr_pkg::ST_EMIT;
          end
        endcase
      end
      crsr_pkg::ST_EMIT: begin
        if (merge_free) begin
          merge_load = 1'b1;
          phase_next = phase_sum;
          count_next = count + 4'd1;
          state_next = crsr_pkg::ST_CHECK;
        end
      end
      default: begin
        state_next = crsr_pkg::ST_IDLE;
      end
    endcase
  end

  // Left and right lanes.
  crsr_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
    .ACC_BITS       (ACC_BITS)
  ) u_lane_left (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lane_ctrl),
    .sample(in_ch.left_sample),
    .frac  (phase[PHASE_FRAC_BITS-1:0]),
    .y     (left_y)
  );

  crsr_lane #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
    .ACC_BITS       (ACC_BITS)
  ) u_lane_right (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (lane_ctrl),
    .sample(right_in),
    .frac  (phase[PHASE_FRAC_BITS-1:0]),
    .y     (right_y)
  );

  // Mono mix, saturation and output register.
  crsr_merge #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .left_y     (left_y),
    .right_y    (right_y),
    .mono_output(mono_output),
    .load       (merge_load),
    .last       (merge_last),
    .free       (merge_free),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

>>> tb/sv/catmull_rom_stereo_resampler_tb.sv
`default_nettype none

module catmull_rom_stereo_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int STEP_BITS   = FRAC_BITS + 3;

  localparam int unsigned ONE_PHASE = 1 << FRAC_BITS;
  localparam int unsigned STEP_LO   = ONE_PHASE >> 3;
  localparam int unsigned STEP_HI   = ONE_PHASE << 2;
  localparam int          MAX_RUN   = 8;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_NEG_ONE = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE = 1;

  // Register index that decodes to nothing.
  localparam logic [crsr_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_FRAMES  = 50;
  localparam int DRAIN_CYCLES  = 80;
  localparam int LONG_HOLD     = 400;
  localparam int QUIET_LIMIT   = 4000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
  } src_frame_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic                   last;
  } out_frame_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                cfg_we    = 1'b0;
  logic [crsr_pkg::CFG_INDEX_BITS-1:0] cfg_index = crsr_pkg::CFG_PHASE_STEP;
  logic [STEP_BITS-1:0]                cfg_data  = '0;

  crsr_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
  crsr_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

  catmull_rom_stereo_resampler #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .PHASE_FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #6 clk = ~clk;

  // Frames waiting to be offered, and output frames still to arrive.
  src_frame_t frames_pending[$];
  out_frame_t expected_frames[$];
  int         frames_queued   = 0;
  int         frames_accepted = 0;
  int         errors          = 0;
  bit         gaps_on         = 1'b1;

  // Resampler state as the testbench sees it.
  longint      hist_l[4];
  longint      hist_r[4];
  int unsigned phase_acc      = 0;
  int unsigned phase_step_q   = ONE_PHASE;
  bit          mono_source_q  = 1'b0;
  bit          mono_output_q  = 1'b0;

  // Round x / 2^s to nearest, ties towards plus infinity.
  function automatic longint round_shift(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_sample(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Catmull-Rom point between d1 and d2, Horner form on doubled coefficients.
  function automatic longint cubic_point(input longint d0, input longint d1,
                                         input longint d2, input longint d3,
                                         input longint f);
    longint c0;
    longint c1;
    longint c2;
    longint h;
    c0 = -d0 + 3 * d1 - 3 * d2 + d3;
    c1 = 2 * d0 - 5 * d1 + 4 * d2 - d3;
    c2 = d2 - d0;
    h = c1 + round_shift(c0 * f, FRAC_BITS);
    h = c2 + round_shift(h * f, FRAC_BITS);
    h = 2 * d1 + round_shift(h * f, FRAC_BITS);
    return round_shift(h, 1);
  endfunction

  // Shift one source frame into the history and queue the output run it causes.
  task automatic resample_frame(input src_frame_t fr);
    longint      l_in;
    longint      r_in;
    longint      yl;
    longint      yr;
    longint      mix;
    int unsigned step;
    int          n;
    int          k;
    out_frame_t  res;
    l_in = longint'($signed(fr.left));
    r_in = mono_source_q ? l_in : longint'($signed(fr.right));
    step = phase_step_q;
    if (step < STEP_LO) step = STEP_LO;
    if (step > STEP_HI) step = STEP_HI;
    for (k = 0; k < 3; k++) begin
      hist_l[k] = hist_l[k+1];
      hist_r[k] = hist_r[k+1];
    end
    hist_l[3] = l_in;
    hist_r[3] = r_in;
    n = 0;
    while (phase_acc < ONE_PHASE && n < MAX_RUN) begin
      yl = cubic_point(hist_l[0], hist_l[1], hist_l[2], hist_l[3], longint'(phase_acc));
      yr = cubic_point(hist_r[0], hist_r[1], hist_r[2], hist_r[3], longint'(phase_acc));
      if (mono_output_q) begin
        mix = round_shift(yl + yr, 1);
        yl  = mix;
        yr  = mix;
      end
      res.left  = SAMPLE_BITS'(clamp_sample(yl));
      res.right = SAMPLE_BITS'(clamp_sample(yr));
      res.last  = !((phase_acc + step < ONE_PHASE) && (n + 1 < MAX_RUN));
      expected_frames.push_back(res);
      phase_acc += step;
      n++;
    end
    phase_acc = (phase_acc >= ONE_PHASE) ? phase_acc - ONE_PHASE : 0;
    phase_acc &= (1 << STEP_BITS) - 1;
  endtask

  // Sender: offers queued frames, with a drawn gap after each transfer.
  src_frame_t offered;
  int         tx_wait;

  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      tx_wait     <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        resample_frame(offered);
        frames_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_wait != 0) begin
          tx_wait     <= tx_wait - 1;
          in_ch.valid <= 1'b0;
        end else if (frames_pending.size() != 0) begin
          offered = frames_pending.pop_front();
          in_ch.left_sample  <= offered.left;
          in_ch.right_sample <= offered.right;
          in_ch.valid        <= 1'b1;
          tx_wait            <= gaps_on ? $urandom_range(0, 4) : 0;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each transfer against the oldest expected frame and
  // paces ready, including one long hold-off while the sender keeps offering.
  out_frame_t want;
  int         rx_wait;
  int         holdoff;
  int         draw;
  bit         long_hold_done;

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready   <= 1'b0;
      rx_wait        <= 0;
      holdoff        <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_frames.size() == 0) begin
          if (errors < REPORT_LIMIT)
            $display("unexpected output: L=%0d R=%0d last=%0b", $signed(out_ch.left_out),
                     $signed(out_ch.right_out), out_ch.last_of_run);
          errors++;
        end else begin
          want = expected_frames.pop_front();
          if (out_ch.left_out !== want.left || out_ch.right_out !== want.right ||
              out_ch.last_of_run !== want.last) begin
            if (errors < REPORT_LIMIT)
              $display("mismatch: expected L=%0d R=%0d last=%0b, got L=%0d R=%0d last=%0b",
                       $signed(want.left), $signed(want.right), want.last,
                       $signed(out_ch.left_out), $signed(out_ch.right_out),
                       out_ch.last_of_run);
            errors++;
          end
        end
      end

      if (holdoff != 0) begin
        holdoff      <= holdoff - 1;
        out_ch.ready <= (holdoff == 1);
      end else if (!long_hold_done && frames_pending.size() > 30 &&
                   expected_frames.size() != 0) begin
        holdoff        <= LONG_HOLD;
        long_hold_done <= 1'b1;
        out_ch.ready   <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        draw = gaps_on ? $urandom_range(0, 4) : 0;
        rx_wait      <= draw;
        out_ch.ready <= (draw == 0);
      end else if (rx_wait != 0) begin
        rx_wait      <= rx_wait - 1;
        out_ch.ready <= (rx_wait == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("catmull_rom_stereo_resampler verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_frame(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
    src_frame_t fr;
    fr.left  = l;
    fr.right = r;
    frames_pending.push_back(fr);
    frames_queued++;
  endtask

  // One register write; the block is idle whenever this is called.
  task automatic write_reg(input logic [crsr_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [STEP_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      crsr_pkg::CFG_PHASE_STEP:  phase_step_q  = value;
      crsr_pkg::CFG_MONO_SOURCE: mono_source_q = value[0];
      crsr_pkg::CFG_MONO_OUTPUT: mono_output_q = value[0];
      default: ;
    endcase
  endtask

  // Wait until every frame is taken and every output has arrived, then let
  // frames that cause no output finish inside the block.
  task automatic settle();
    do @(posedge clk);
    while (frames_accepted != frames_queued || expected_frames.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] random_sample(input logic [SAMPLE_BITS-1:0] prev);
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return SAMPLE_MAX;
          1:       return SAMPLE_MIN;
          2:       return '0;
          default: return SAMPLE_NEG_ONE;
        endcase
      end
      1:       return SAMPLE_BITS'($urandom_range(0, 1023)) - SAMPLE_BITS'(512);
      2, 3:    return prev + SAMPLE_BITS'($urandom_range(0, 65535)) - SAMPLE_BITS'(32768);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [STEP_BITS-1:0] random_step();
    case ($urandom_range(0, 5))
      0:       return STEP_BITS'(STEP_LO);
      1:       return STEP_BITS'(STEP_HI);
      2:       return STEP_BITS'($urandom_range(STEP_LO, STEP_HI));
      3:       return STEP_BITS'($urandom());
      4:       return STEP_BITS'(ONE_PHASE);
      default: return STEP_BITS'($urandom_range(STEP_LO, ONE_PHASE));
    endcase
  endfunction

  // Stimulus: directed phases first, then random phases with fresh settings.
  logic [SAMPLE_BITS-1:0] lp;
  logic [SAMPLE_BITS-1:0] rp;
  int                     ph;
  int                     k;

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.left_sample  = '0;
    in_ch.right_sample = '0;
    out_ch.ready       = 1'b0;
    for (k = 0; k < 4; k++) begin
      hist_l[k] = 0;
      hist_r[k] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Unit step in stereo: full-scale swings that overshoot and saturate.
    write_reg(crsr_pkg::CFG_PHASE_STEP, STEP_BITS'(ONE_PHASE));
    write_reg(crsr_pkg::CFG_MONO_SOURCE, '0);
    write_reg(crsr_pkg::CFG_MONO_OUTPUT, '0);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    queue_frame('0, '0);
    queue_frame(SAMPLE_NEG_ONE, SAMPLE_ONE);
    queue_frame(SAMPLE_MAX, SAMPLE_MAX);
    queue_frame(SAMPLE_MIN, SAMPLE_MIN);
    settle();

    // A step below one eighth is raised to one eighth: full runs of eight.
    write_reg(crsr_pkg::CFG_PHASE_STEP, '0);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    settle();

    // A step above four is cut to four, so most frames enter with the
    // phase at or above one and give no output.
    write_reg(crsr_pkg::CFG_PHASE_STEP, '1);
    queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    queue_frame(SAMPLE_ONE, SAMPLE_NEG_ONE);
    queue_frame('0, SAMPLE_MAX);
    queue_frame(SAMPLE_MAX, '0);
    queue_frame(SAMPLE_MIN, SAMPLE_MIN);
    settle();

    // Mono source, written with upper data bits set; a write to the unused
    // index must leave the step alone.
    write_reg(crsr_pkg::CFG_PHASE_STEP, STEP_BITS'(ONE_PHASE + (ONE_PHASE >> 1)));
    write_reg(crsr_pkg::CFG_MONO_SOURCE, '1);
    write_reg(crsr_pkg::CFG_MONO_OUTPUT, ~STEP_BITS'(1));
    write_reg(CFG_UNUSED_INDEX, '0);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    queue_frame(SAMPLE_MIN, SAMPLE_MAX);
    queue_frame(SAMPLE_MAX, '0);
    queue_frame(SAMPLE_NEG_ONE, SAMPLE_MAX);
    settle();

    // Mono output: the mix of overshooting channels must saturate too.
    write_reg(crsr_pkg::CFG_PHASE_STEP, STEP_BITS'(ONE_PHASE >> 1));
    write_reg(crsr_pkg::CFG_MONO_SOURCE, ~STEP_BITS'(1));
    write_reg(crsr_pkg::CFG_MONO_OUTPUT, STEP_BITS'(1));
    queue_frame(SAMPLE_MAX, SAMPLE_MAX);
    queue_frame(SAMPLE_MIN, SAMPLE_MIN);
    queue_frame(SAMPLE_MAX, SAMPLE_MAX);
    queue_frame(SAMPLE_MAX, SAMPLE_MIN);
    settle();

    // Random phases; one of them runs with no idling on either side.
    lp = '0;
    rp = '0;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(crsr_pkg::CFG_PHASE_STEP, random_step());
      write_reg(crsr_pkg::CFG_MONO_SOURCE, STEP_BITS'($urandom()));
      write_reg(crsr_pkg::CFG_MONO_OUTPUT, STEP_BITS'($urandom()));
      gaps_on <= (ph != 2);
      for (k = 0; k < PHASE_FRAMES; k++) begin
        lp = random_sample(lp);
        rp = random_sample(rp);
        queue_frame(lp, rp);
      end
      settle();
    end

    if (errors == 0)
      $display("catmull_rom_stereo_resampler verification clean");
    else
      $display("catmull_rom_stereo_resampler verification failed");
    $finish;
  end

endmodule

`default_nettype wire
